>>> hw/rtl/dsa_pkg.sv
// Shared constants, codes and control/status bundles of the descriptor slot allocator.
package dsa_pkg;

  localparam int MAX_SLOTS   = 1024;
  localparam int ADDR_BITS   = 48;
  localparam int SLOT_W      = $clog2(MAX_SLOTS);
  localparam int CNT_W       = $clog2(MAX_SLOTS + 1);
  localparam int STRIDE_W    = 9;
  localparam int RAW_W       = 11;
  localparam int COUNT_REG_W = 11;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 3;

  localparam int CFG_DW = 64;
  localparam int CFG_AW = 5;

  localparam int IN_FIELDS_W  = RAW_W + ADDR_BITS;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = SLOT_W + 2 * ADDR_BITS + CNT_W + 1;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Divider retires this many quotient bits per cycle.
  localparam int DIV_STEP_BITS = 4;
  localparam int DIV_CYC       = (ADDR_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
  localparam int DIV_W         = DIV_CYC * DIV_STEP_BITS;
  localparam int DIV_CNT_W     = $clog2(DIV_CYC + 1);
  localparam int REM_W         = STRIDE_W + 1;

  localparam logic [CNT_W-1:0]     RST_SLOT_COUNT  = CNT_W'(MAX_SLOTS);
  localparam logic [STRIDE_W-1:0]  RST_SLOT_STRIDE = STRIDE_W'(32);

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC     = 2'd0,
    OP_FREE_IDX  = 2'd1,
    OP_FREE_ADDR = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_EMPTY       = 3'd1,
    ST_BAD_INDEX   = 3'd2,
    ST_DOUBLE_FREE = 3'd3,
    ST_MISALIGNED  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    REG_SLOT_COUNT  = 2'd0,
    REG_SLOT_STRIDE = 2'd1,
    REG_CPU_BASE    = 2'd2,
    REG_GPU_BASE    = 2'd3
  } reg_t;

  typedef struct packed {
    logic    accept;
    logic    clr_init;
    logic    clr_step;
    logic    set_idx_raw;
    logic    div_start;
    logic    set_idx_q;
    logic    pop;
    logic    calc_addr;
    logic    give_idx;
    logic    push;
    logic    set_status;
    status_t status;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic raw_neg;
    logic depth_zero;
    logic stride_zero;
    logic div_done;
    logic rem_nz;
    logic q_oob;
    logic idx_oob;
    logic mark_set;
    logic depth_full;
    logic out_full;
    logic sweep_last;
  } sts_t;

endpackage

>>> hw/rtl/dsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dsa_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/dsa_div.sv
// Iterative restoring divider of an address offset by the slot stride.
module dsa_div import dsa_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [DIV_W-1:0]    dividend,
  input  logic [STRIDE_W-1:0] divisor,
  output logic [DIV_W-1:0]    quot,
  output logic [STRIDE_W-1:0] rem,
  output logic                done
);

  logic [DIV_W-1:0]     dq_r, dq_nxt;
  logic [STRIDE_W-1:0]  rem_r, rem_nxt;
  logic [STRIDE_W-1:0]  dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [REM_W-1:0]     sh;

  // Each cycle brings in four dividend bits, most significant first, and
  // shifts the matching quotient bits into the bottom of the same register.
  always_comb begin
    dq_nxt  = dq_r;
    rem_nxt = rem_r;
    sh      = '0;
    for (int i = 0; i < DIV_STEP_BITS; i++) begin
      sh     = {rem_nxt, dq_nxt[DIV_W-1]};
      dq_nxt = {dq_nxt[DIV_W-2:0], 1'b0};
      if (sh >= {1'b0, dvs_r}) begin
        rem_nxt   = STRIDE_W'(sh - {1'b0, dvs_r});
        dq_nxt[0] = 1'b1;
      end else begin
        rem_nxt = sh[STRIDE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= DIV_CNT_W'(DIV_CYC);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq_r  <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (cnt_r != '0) begin
      dq_r  <= dq_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quot = dq_r;
  assign rem  = rem_r;
  assign done = (cnt_r == '0);

endmodule

>>> hw/rtl/dsa_ctrl.sv
// Controller state machine sequencing refill sweeps and allocate/free items.
module dsa_ctrl import dsa_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic count_wr,
  input  logic in_tvalid,
  input  sts_t sts,
  output cmd_t cmd,
  output logic in_tready
);

  typedef enum logic [3:0] {
    S_CLR_INIT,
    S_CLR,
    S_IDLE,
    S_DECODE,
    S_POP,
    S_ADDR,
    S_DIV,
    S_CHECK,
    S_MARK,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_tready = 1'b0;
    case (state_r)
      S_CLR_INIT: begin
        cmd.clr_init = 1'b1;
        state_nxt    = S_CLR;
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.op)
          OP_ALLOC: begin
            if (sts.depth_zero) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_EMPTY;
              state_nxt      = S_FINISH;
            end else begin
              state_nxt = S_POP;
            end
          end
          OP_FREE_IDX: begin
            if (sts.raw_neg) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_BAD_INDEX;
              state_nxt      = S_FINISH;
            end else begin
              cmd.set_idx_raw = 1'b1;
              state_nxt       = S_CHECK;
            end
          end
          OP_FREE_ADDR: begin
            if (sts.stride_zero) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_MISALIGNED;
              state_nxt      = S_FINISH;
            end else begin
              cmd.div_start = 1'b1;
              state_nxt     = S_DIV;
            end
          end
          default: begin
            cmd.set_status = 1'b1;
            cmd.status     = ST_BAD_INDEX;
            state_nxt      = S_FINISH;
          end
        endcase
      end
      S_POP: begin
        cmd.pop   = 1'b1;
        state_nxt = S_ADDR;
      end
      S_ADDR: begin
        cmd.calc_addr = 1'b1;
        state_nxt     = S_FINISH;
      end
      S_DIV: begin
        if (sts.div_done) begin
          if (sts.rem_nz) begin
            cmd.set_status = 1'b1;
            cmd.status     = ST_MISALIGNED;
            state_nxt      = S_FINISH;
          end else if (sts.q_oob) begin
            cmd.set_status = 1'b1;
            cmd.status     = ST_BAD_INDEX;
            state_nxt      = S_FINISH;
          end else begin
            cmd.set_idx_q = 1'b1;
            state_nxt     = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (sts.idx_oob) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_BAD_INDEX;
          state_nxt      = S_FINISH;
        end else begin
          state_nxt = S_MARK;
        end
      end
      S_MARK: begin
        cmd.give_idx = 1'b1;
        if (!sts.mark_set || sts.depth_full) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_DOUBLE_FREE;
        end else begin
          cmd.push = 1'b1;
        end
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!sts.out_full) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLR_INIT;
      end
    endcase
    // A new slot count restarts the refill sweep.
    if (count_wr) begin
      state_nxt = S_CLR_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hw/rtl/dsa_datapath.sv
// Datapath: free stack and allocation marks, address arithmetic, output register.
module dsa_datapath import dsa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic [OP_W-1:0]       in_op,
  input  logic [RAW_W-1:0]      in_slot_index,
  input  logic [ADDR_BITS-1:0]  in_slot_address,
  input  logic [CNT_W-1:0]      slot_count,
  input  logic [STRIDE_W-1:0]   slot_stride,
  input  logic [ADDR_BITS-1:0]  cpu_base,
  input  logic [ADDR_BITS-1:0]  gpu_base,
  input  logic                  out_tready,
  output logic                  out_tvalid,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [STATUS_W-1:0]   out_tuser
);

  localparam int PROD_W = STRIDE_W + SLOT_W;

  logic [OP_W-1:0]       op_r;
  logic [RAW_W-1:0]      raw_r;
  logic [ADDR_BITS-1:0]  addr_r;
  logic [CNT_W-1:0]      depth_r;
  logic [SLOT_W-1:0]     sweep_r;
  logic [SLOT_W-1:0]     idx_r;
  logic [PROD_W-1:0]     prod_r;
  status_t               res_status_r;
  logic [SLOT_W-1:0]     res_idx_r;
  logic [ADDR_BITS-1:0]  res_cpu_r;
  logic [ADDR_BITS-1:0]  res_gpu_r;
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [STATUS_W-1:0]   out_user_r;

  logic [ADDR_BITS-1:0]  offset;
  logic [DIV_W-1:0]      quot;
  logic [STRIDE_W-1:0]   rem;
  logic                  div_done;

  logic                  stk_we;
  logic [SLOT_W-1:0]     stk_waddr;
  logic [SLOT_W-1:0]     stk_wdata;
  logic [SLOT_W-1:0]     stk_raddr;
  logic [SLOT_W-1:0]     stk_rd;
  logic                  mark_we;
  logic [SLOT_W-1:0]     mark_waddr;
  logic [0:0]            mark_wdata;
  logic [0:0]            mark_rd;
  logic [CNT_W-1:0]      fill_val;

  // The refill sweep writes position k with count-1-k so that slot 0 ends on top.
  assign fill_val  = slot_count - CNT_W'(1) - CNT_W'(sweep_r);
  assign stk_raddr = SLOT_W'(depth_r - CNT_W'(1));

  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = sweep_r;
    stk_wdata = fill_val[SLOT_W-1:0];
    if (cmd.clr_step) begin
      stk_we = 1'b1;
    end else if (cmd.push) begin
      stk_we    = 1'b1;
      stk_waddr = depth_r[SLOT_W-1:0];
      stk_wdata = idx_r;
    end
  end

  always_comb begin
    mark_we    = 1'b0;
    mark_waddr = sweep_r;
    mark_wdata = 1'b0;
    if (cmd.clr_step) begin
      mark_we = 1'b1;
    end else if (cmd.pop) begin
      mark_we    = 1'b1;
      mark_waddr = stk_rd;
      mark_wdata = 1'b1;
    end else if (cmd.push) begin
      mark_we    = 1'b1;
      mark_waddr = idx_r;
    end
  end

  dsa_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_SLOTS)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rd)
  );

  dsa_ram #(.WIDTH(1), .DEPTH(MAX_SLOTS)) u_mark (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (mark_wdata),
    .raddr (idx_r),
    .rdata (mark_rd)
  );

  assign offset = addr_r - cpu_base;

  dsa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (DIV_W'(offset)),
    .divisor  (slot_stride),
    .quot     (quot),
    .rem      (rem),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r     <= '0;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_init) begin
        depth_r <= slot_count;
        sweep_r <= '0;
      end else if (cmd.clr_step) begin
        sweep_r <= sweep_r + 1'b1;
      end
      if (cmd.pop) begin
        depth_r <= depth_r - 1'b1;
      end else if (cmd.push) begin
        depth_r <= depth_r + 1'b1;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r         <= in_op;
      raw_r        <= in_slot_index;
      addr_r       <= in_slot_address;
      res_status_r <= ST_OK;
      res_idx_r    <= '0;
      res_cpu_r    <= '0;
      res_gpu_r    <= '0;
    end
    if (cmd.set_idx_raw) begin
      idx_r <= raw_r[SLOT_W-1:0];
    end
    if (cmd.set_idx_q) begin
      idx_r <= quot[SLOT_W-1:0];
    end
    if (cmd.pop) begin
      idx_r     <= stk_rd;
      res_idx_r <= stk_rd;
      prod_r    <= PROD_W'(slot_stride) * PROD_W'(stk_rd);
    end
    if (cmd.calc_addr) begin
      res_cpu_r <= cpu_base + ADDR_BITS'(prod_r);
      res_gpu_r <= (gpu_base == '0) ? '0 : gpu_base + ADDR_BITS'(prod_r);
    end
    if (cmd.give_idx) begin
      res_idx_r <= idx_r;
    end
    if (cmd.set_status) begin
      res_status_r <= cmd.status;
    end
    if (cmd.load_out) begin
      out_data_r <= OUT_DATA_W'({(depth_r == slot_count), depth_r,
                                 res_gpu_r, res_cpu_r, res_idx_r});
      out_user_r <= res_status_r;
    end
  end

  assign sts.op          = op_t'(op_r);
  assign sts.raw_neg     = raw_r[RAW_W-1];
  assign sts.depth_zero  = (depth_r == '0);
  assign sts.stride_zero = (slot_stride == '0);
  assign sts.div_done    = div_done;
  assign sts.rem_nz      = (rem != '0);
  assign sts.q_oob       = (quot >= DIV_W'(slot_count));
  assign sts.idx_oob     = (CNT_W'(idx_r) >= slot_count);
  assign sts.mark_set    = mark_rd[0];
  assign sts.depth_full  = (depth_r >= CNT_W'(MAX_SLOTS));
  assign sts.out_full    = out_valid_r && !out_tready;
  assign sts.sweep_last  = (sweep_r == SLOT_W'(MAX_SLOTS - 1));

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

>>> hw/rtl/descriptor_slot_allocator_unit.sv
// Top level of the descriptor slot allocator: register port, controller and datapath.
//
// The block hands out descriptor slots from a pool of up to 1024 through a
// last-in-first-out stack of free indices. Items arrive on the in_ stream:
// in_tuser carries the operation (allocate, free by index, free by CPU
// address) and in_tdata the index and address. Each item yields exactly one
// result item on the out_ stream with its status code in out_tuser and the
// slot index, CPU and GPU addresses, free count and all-free flag in out_tdata,
// unless a slot count write restarts the refill before that result is loaded.
// The block works on one item at a time. Free by address runs through the
// divider, which retires four quotient bits per cycle over a 48-bit offset.
// A new item is taken in the cycle after the previous result is loaded into
// the output register, so the block keeps accepting while a result waits
// there; if the receiver holds out_tready low, the following result waits in
// the controller and the input stalls behind it. After reset, and after every
// write of the slot count register, a refill sweep rewrites the free stack
// and clears every allocation mark; in_tready stays low during the sweep
// while register writes are taken.
// Registers sit on an APB-style port at byte addresses 0, 8, 16 and 24.
module descriptor_slot_allocator_unit import dsa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // slot_index[10:0], slot_address[58:11]
  input  logic [OP_W-1:0]       in_tuser,   // op[1:0]
  // Result stream.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // given_index[9:0], cpu_address[57:10],
                                            // gpu_address[105:58], free_count[116:106],
                                            // all_free[117]
  output logic [STATUS_W-1:0]   out_tuser,  // status[2:0]
  // Register port.
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_AW-1:0]     cfg_paddr,
  input  logic [CFG_DW-1:0]     cfg_pwdata,
  output logic [CFG_DW-1:0]     cfg_prdata,
  output logic                  cfg_pready
);

  logic [CNT_W-1:0]       slot_count_r, slot_count_nxt;
  logic [STRIDE_W-1:0]    slot_stride_r;
  logic [ADDR_BITS-1:0]   cpu_base_r;
  logic [ADDR_BITS-1:0]   gpu_base_r;
  logic                   cfg_wr;
  reg_t                   cfg_sel;
  logic [COUNT_REG_W-1:0] count_wv;
  logic                   count_wr;
  cmd_t                   cmd;
  sts_t                   sts;

  // Registers sit every eight bytes, so the low address bits do not select.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_sel    = reg_t'(cfg_paddr[CFG_AW-1:3]);
  assign count_wr   = cfg_wr && (cfg_sel == REG_SLOT_COUNT);

  // A slot count above the pool size saturates to the pool size.
  assign count_wv       = cfg_pwdata[COUNT_REG_W-1:0];
  assign slot_count_nxt = (count_wv > COUNT_REG_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS)
                                                               : CNT_W'(count_wv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r  <= RST_SLOT_COUNT;
      slot_stride_r <= RST_SLOT_STRIDE;
      cpu_base_r    <= '0;
      gpu_base_r    <= '0;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_SLOT_COUNT:  slot_count_r  <= slot_count_nxt;
        REG_SLOT_STRIDE: slot_stride_r <= cfg_pwdata[STRIDE_W-1:0];
        REG_CPU_BASE:    cpu_base_r    <= cfg_pwdata[ADDR_BITS-1:0];
        REG_GPU_BASE:    gpu_base_r    <= cfg_pwdata[ADDR_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_SLOT_COUNT:  cfg_prdata = CFG_DW'(slot_count_r);
      REG_SLOT_STRIDE: cfg_prdata = CFG_DW'(slot_stride_r);
      REG_CPU_BASE:    cfg_prdata = CFG_DW'(cpu_base_r);
      REG_GPU_BASE:    cfg_prdata = CFG_DW'(gpu_base_r);
      default:         cfg_prdata = '0;
    endcase
  end

  dsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .count_wr  (count_wr),
    .in_tvalid (in_tvalid),
    .sts       (sts),
    .cmd       (cmd),
    .in_tready (in_tready)
  );

  dsa_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_op           (in_tuser),
    .in_slot_index   (in_tdata[RAW_W-1:0]),
    .in_slot_address (in_tdata[RAW_W +: ADDR_BITS]),
    .slot_count      (slot_count_r),
    .slot_stride     (slot_stride_r),
    .cpu_base        (cpu_base_r),
    .gpu_base        (gpu_base_r),
    .out_tready      (out_tready),
    .out_tvalid      (out_tvalid),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser)
  );

  // Result fields seen by the checks below.
  logic [ADDR_BITS-1:0] out_cpu_address;
  logic [ADDR_BITS-1:0] out_gpu_address;

  assign out_cpu_address = out_tdata[SLOT_W +: ADDR_BITS];
  assign out_gpu_address = out_tdata[SLOT_W + ADDR_BITS +: ADDR_BITS];

  // Only a successful allocation carries addresses.
  a_addr_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_OK) |-> (out_cpu_address == '0) &&
                                           (out_gpu_address == '0))
    else $error("failed item carries a nonzero address");

  // One item in flight: an accepted item blocks the next one in the following cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while an item is in progress");

  // Writing the slot count starts a refill, during which no item is taken.
  a_refill_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    count_wr |=> !in_tready)
    else $error("input ready right after a slot count write");

endmodule
